// ===== rtl/pecc_pkg.sv =====
// ---------------------------------------------------------------------------
// PRBS excitation and encoder capture package
// Shared item types, register indexes, command/status groups and constants.
// ---------------------------------------------------------------------------
`default_nettype none

package pecc_pkg;

    // Function codes carried in the input item
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_SELECT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_PERIOD  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_MV = 8'd3;
    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values
    localparam logic        RST_MOTOR_SELECT = 1'b1;
    localparam logic [7:0]  RST_HOLD_PERIOD  = 8'd10;
    localparam logic [15:0] RST_SAMPLE_COUNT = 16'd10000;
    localparam logic [15:0] RST_AMPLITUDE_MV = 16'd5000;

    // PRBS-31 generator, polynomial x^31 + x^28 + 1
    localparam int unsigned LFSR_W = 31;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 31'h7FFF_FFFF;
    localparam int unsigned TAP_A = 30;
    localparam int unsigned TAP_B = 27;

    // Drive scaling: Q3.12 result of amplitude * 4096 / battery
    localparam int unsigned Q_SHIFT    = 12;
    localparam int unsigned DIVISOR_W  = 16;
    localparam int unsigned DIVIDEND_W = 16 + Q_SHIFT;
    localparam logic [15:0] DRIVE_POS_SAT = 16'h7FFF;
    localparam logic [15:0] DRIVE_NEG_SAT = 16'h8000;
    localparam logic [DIVIDEND_W-1:0] MAG_POS_MAX = 28'd32767;
    localparam logic [DIVIDEND_W-1:0] MAG_NEG_MAX = 28'd32768;

    typedef struct packed {
        logic        func;
        logic [31:0] left_count;
        logic [31:0] right_count;
        logic [15:0] battery_mv;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               excitation_bit;
        logic signed [31:0] position_delta;
        logic        [15:0] sample_index;
        logic               last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic start_run;   // start transaction: baseline capture
        logic capture;     // tick of a run accepted: latch the encoder
        logic div_start;   // new PRBS level needed: launch the divider
        logic commit;      // update state and load the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic running;
        logic hold_zero;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/pecc_div.sv =====
// ---------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module pecc_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [pecc_pkg::DIVIDEND_W-1:0]   i_dividend,
    input  wire logic [pecc_pkg::DIVISOR_W-1:0]    i_divisor,
    output logic                                   o_done,
    output logic [pecc_pkg::DIVIDEND_W-1:0]        o_quotient
);
    import pecc_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_divisor;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;
    logic [DIVISOR_W:0]    diff;

    // One trial subtraction per cycle. A zero divisor always fits, which
    // gives an all-ones quotient and so a saturated drive downstream.
    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        fits  = (trial >= {1'b0, r_divisor});
        diff  = trial - {1'b0, r_divisor};
    end

    // Control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== rtl/pecc_dp.sv =====
// ---------------------------------------------------------------------------
// Excitation datapath
// Configuration registers, PRBS generator, run state, drive scaling and the
// output register.
// ---------------------------------------------------------------------------
`default_nettype none

module pecc_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pecc_pkg::t_cmd                    i_cmd,
    output pecc_pkg::t_status                      o_status,
    input  wire pecc_pkg::t_in_item                i_in_data,
    input  wire logic                              i_cfg_valid,
    input  wire logic [pecc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pecc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output pecc_pkg::t_out_item                    o_out_data
);
    import pecc_pkg::*;

    // Configuration
    logic        r_motor_select;
    logic [7:0]  r_hold_period;
    logic [15:0] r_sample_count;
    logic [15:0] r_amplitude_mv;

    // Run state
    logic [LFSR_W-1:0] r_lfsr;
    logic [31:0]       r_prev_count;
    logic [31:0]       r_cur_count;
    logic [15:0]       r_index;
    logic [15:0]       r_held_drive;
    logic              r_held_bit;
    logic [7:0]        r_hold;
    logic              r_running;

    // Output register
    logic      r_out_valid;
    t_out_item r_out_data;

    logic                  div_done;
    logic [DIVIDEND_W-1:0] quotient;

    logic [31:0]       sel_count;
    logic              fb;
    logic [LFSR_W-1:0] n_lfsr;
    logic [15:0]       sat_drive;
    logic [15:0]       n_held_drive;
    logic              n_held_bit;
    logic [7:0]        period;
    logic [8:0]        hold_inc;
    logic [7:0]        n_hold;
    logic [16:0]       index_inc;
    logic              is_last;
    logic              out_free;

    pecc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_amplitude_mv, Q_SHIFT'(0)}),
        .i_divisor  (i_in_data.battery_mv),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Encoder selection, PRBS step, saturation and counter updates
    always_comb begin
        sel_count = r_motor_select ? i_in_data.left_count : i_in_data.right_count;

        fb     = r_lfsr[TAP_A] ^ r_lfsr[TAP_B];
        n_lfsr = {r_lfsr[LFSR_W-2:0], fb};

        if (fb) begin
            sat_drive = (quotient > MAG_POS_MAX) ? DRIVE_POS_SAT : quotient[15:0];
        end else begin
            sat_drive = (quotient > MAG_NEG_MAX) ? DRIVE_NEG_SAT
                                                 : (~quotient[15:0] + 16'd1);
        end

        if (r_hold == '0) begin
            n_held_bit   = fb;
            n_held_drive = sat_drive;
        end else begin
            n_held_bit   = r_held_bit;
            n_held_drive = r_held_drive;
        end

        period    = (r_hold_period == '0) ? 8'd1 : r_hold_period;
        hold_inc  = {1'b0, r_hold} + 9'd1;
        n_hold    = (hold_inc >= {1'b0, period}) ? 8'd0 : hold_inc[7:0];
        index_inc = {1'b0, r_index} + 17'd1;
        is_last   = (index_inc >= {1'b0, r_sample_count});
        out_free  = !r_out_valid || i_out_ready;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_select <= RST_MOTOR_SELECT;
            r_hold_period  <= RST_HOLD_PERIOD;
            r_sample_count <= RST_SAMPLE_COUNT;
            r_amplitude_mv <= RST_AMPLITUDE_MV;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MOTOR_SELECT: r_motor_select <= i_cfg_data[0];
                CFG_HOLD_PERIOD:  r_hold_period  <= i_cfg_data[7:0];
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data;
                CFG_AMPLITUDE_MV: r_amplitude_mv <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Run state: baseline on start, generator and counters on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr       <= LFSR_SEED;
            r_prev_count <= '0;
            r_index      <= '0;
            r_held_drive <= '0;
            r_held_bit   <= 1'b0;
            r_hold       <= '0;
            r_running    <= 1'b0;
        end else if (i_cmd.start_run) begin
            r_prev_count <= sel_count;
            r_index      <= '0;
            r_hold       <= '0;
            r_running    <= 1'b1;
        end else if (i_cmd.commit) begin
            if (r_hold == '0) begin
                r_lfsr <= n_lfsr;
            end
            r_held_bit   <= n_held_bit;
            r_held_drive <= n_held_drive;
            r_hold       <= n_hold;
            r_prev_count <= r_cur_count;
            r_index      <= index_inc[15:0];
            if (is_last) begin
                r_running <= 1'b0;
            end
        end
    end

    // Encoder count of the tick in progress
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cur_count <= sel_count;
        end
    end

    // Output register: loads on commit, empties when the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data.drive          <= n_held_drive;
            r_out_data.excitation_bit <= n_held_bit;
            r_out_data.position_delta <= r_cur_count - r_prev_count;
            r_out_data.sample_index   <= r_index;
            r_out_data.last           <= is_last;
        end
    end

    assign o_status.running   = r_running;
    assign o_status.hold_zero = (r_hold == '0);
    assign o_status.div_done  = div_done;
    assign o_status.out_free  = out_free;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/pecc_ctrl.sv =====
// ---------------------------------------------------------------------------
// Excitation controller
// Sequences each tick of a run through capture, division if due, and commit.
// ---------------------------------------------------------------------------
`default_nettype none

module pecc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_func,
    input  wire pecc_pkg::t_status  i_status,
    output logic                    o_in_ready,
    output pecc_pkg::t_cmd          o_cmd
);
    import pecc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        accept  = i_in_valid && (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_START) begin
                        o_cmd.start_run = 1'b1;
                    end else if (i_status.running) begin
                        o_cmd.capture = 1'b1;
                        if (i_status.hold_zero) begin
                            o_cmd.div_start = 1'b1;
                            n_state         = ST_DIV;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/prbs_excitation_and_encoder_capture_unit.sv =====
// ---------------------------------------------------------------------------
// PRBS excitation and encoder capture unit
// Top level: controller, datapath and the port-side configuration channel.
// ---------------------------------------------------------------------------
// Usage
// The input channel takes one transaction per item: a start (func 0) latches
// the selected encoder as the baseline and arms a run; a tick (func 1) during
// a run yields one sample on the output channel, a tick outside a run yields
// nothing. Configuration writes arrive on their own channel, are always
// accepted, and should only be issued while the unit is idle.
// A start or an ignored tick completes in the cycle it is accepted. A tick
// that holds the current PRBS level moves from the accept state to the emit
// state, which loads the output register once it is free; a tick that draws
// a new level also runs the 28-step restoring divider for the drive: after
// the accept come the divider iterations, the controller seeing it finish
// and the output load. The divider iteration sets the worst-case rate.
// The output register frees the input side: the next transaction is taken
// while a sample still waits. If the receiver stalls, the following sample
// waits in the controller until the output register empties.
// Reset restores the register defaults, seeds the generator with all ones
// and leaves the unit idle with no run armed.
// ---------------------------------------------------------------------------
`default_nettype none

module prbs_excitation_and_encoder_capture_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire pecc_pkg::t_in_item                i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output pecc_pkg::t_out_item                    o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pecc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [pecc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pecc_pkg::*;

    t_cmd    cmd;
    t_status status;

    pecc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    pecc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // Register writes are always accepted
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/pecc_checker.sv =====
// ---------------------------------------------------------------------------
// PRBS excitation unit port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module pecc_checker (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  o_in_ready,
    input  wire pecc_pkg::t_in_item    i_in_data,
    input  wire logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    input  wire pecc_pkg::t_out_item   o_out_data
);
    import pecc_pkg::*;

    // A stalled sample stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output sample withdrawn while stalled");

    // A start transaction never occupies the unit beyond its own cycle.
    a_start_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.func == FUNC_START) |=> o_in_ready)
        else $error("start transaction blocked the input channel");

    // A fresh sample is only produced while the input side is busy.
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("sample appeared without a tick in progress");

    // A positive excitation level never yields a negative drive.
    a_drive_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.excitation_bit |-> !o_out_data.drive[15])
        else $error("drive sign disagrees with the excitation bit");

endmodule

bind prbs_excitation_and_encoder_capture_unit pecc_checker u_pecc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
